// ===== rtl/uart_crlf_line_assembler_queue_macros.svh =====
// ----------------------------------------------------------------------------
// uart_crlf_line_assembler_queue_macros
// Assertion macros for the CRLF line assembler queue.
// ----------------------------------------------------------------------------
`ifndef UART_CRLF_LINE_ASSEMBLER_QUEUE_MACROS_SVH
`define UART_CRLF_LINE_ASSEMBLER_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

`define UCLQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define UCLQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define UCLQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define UCLQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/uclq_pkg.sv =====
// ----------------------------------------------------------------------------
// uclq_pkg
// Constants and types for the CRLF line assembler queue.
// ----------------------------------------------------------------------------
`default_nettype none

package uclq_pkg;

  localparam int LINE_BYTES  = 64;
  localparam int QUEUE_LINES = 8;

  // One spare row holds the line under assembly.
  localparam int ROWS      = QUEUE_LINES + 1;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int CNT_W     = $clog2(LINE_BYTES);
  localparam int MEM_DEPTH = ROWS << CNT_W;

  localparam logic [7:0] ERR_MASK = 8'h18;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [1:0] {
    OP_RX    = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } uclq_op_t;

endpackage

`default_nettype wire

// ===== rtl/uart_crlf_line_assembler_queue.sv =====
// ----------------------------------------------------------------------------
// uart_crlf_line_assembler_queue
// Assembles received UART bytes into lines, ended by CRLF or on overflow,
// kept in a history queue; lines are read byte by byte, measured or cleared.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low; busy
//   stays low, so a request may be issued every cycle. in_opcode selects a
//   received byte (with its error flags), a read of in_slot/in_position, a
//   clear of in_slot, or no operation.
//   Every request gives exactly one result in the next cycle, marked by
//   out_valid for a single cycle: throughput one request per cycle; the
//   result is registered, as is the read port of the line memory.
//   Line bytes are written straight into a spare row of the line memory, so a
//   finished line is pushed by moving the newest pointer and writing its
//   length; no copy is done.
//   The receiver cannot stall; results must be taken as they come.
//   Reset clears the assembly count, the newest pointer and all line lengths;
//   the line memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "uart_crlf_line_assembler_queue_macros.svh"

module uart_crlf_line_assembler_queue
  import uclq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_opcode,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_frame_error,
  input  wire logic       in_overrun_error,
  input  wire logic [2:0] in_slot,
  input  wire logic [5:0] in_position,
  output logic            out_valid,
  output logic            out_line_pushed,
  output logic [5:0]      out_pushed_length,
  output logic [7:0]      out_read_byte,
  output logic [5:0]      out_slot_length
);

  logic [7:0]       mem [MEM_DEPTH];
  logic [CNT_W-1:0] len_r [ROWS];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [ROW_W-1:0] np_r, np_nxt;
  logic [CNT_W-1:0] fz_r, fz_nxt;
  logic             fz_valid_r, fz_valid_nxt;
  logic             last_cr_r, last_cr_nxt;

  logic             out_valid_r;
  logic             line_pushed_r;
  logic [5:0]       pushed_len_r;
  logic             rd_hit_r;
  logic [7:0]       rd_data_r;
  logic [5:0]       slot_len_r;

  logic             accept;
  uclq_op_t         op;
  logic [7:0]       status;
  logic             rx_err;
  logic             crlf;
  logic             overflow;
  logic             push;
  logic             mem_we;
  logic             clr;
  logic [ROW_W-1:0] asm_row;
  logic [ROW_W:0]   esum;
  logic [ROW_W-1:0] ent;
  logic             slot_ok;
  logic [CNT_W-1:0] slot_len;
  logic             rd_hit;
  logic [CNT_W-1:0] keep;
  logic [CNT_W-1:0] push_len;
  logic [CNT_W-1:0] rd_col;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign op     = uclq_op_t'(in_opcode);

  assign asm_row = (np_r == '0) ? ROW_W'(ROWS - 1) : np_r - 1'b1;
  assign esum    = {1'b0, np_r} + (ROW_W + 1)'(in_slot);
  assign ent     = (esum >= (ROW_W + 1)'(ROWS)) ? ROW_W'(esum - (ROW_W + 1)'(ROWS))
                                                : esum[ROW_W-1:0];
  assign slot_ok  = {3'b000, in_slot} < 6'(QUEUE_LINES);
  assign slot_len = len_r[ent];
  assign rd_hit   = (9'(in_position) < 9'(slot_len)) &&
                    (9'(in_position) < 9'(LINE_BYTES));
  assign rd_col   = CNT_W'(in_position);

  assign status   = {3'b000, in_frame_error, in_overrun_error, 3'b000};
  assign rx_err   = |(status & ERR_MASK);
  assign overflow = count_r >= CNT_W'(LINE_BYTES - 1);
  assign crlf     = (in_rx_byte == CH_LF) && (count_r != '0) && last_cr_r;
  assign keep     = count_r - 1'b1;
  assign push_len = (fz_valid_r && (fz_r < keep)) ? fz_r : keep;

  always_comb begin
    count_nxt    = count_r;
    np_nxt       = np_r;
    fz_nxt       = fz_r;
    fz_valid_nxt = fz_valid_r;
    last_cr_nxt  = last_cr_r;
    push         = 1'b0;
    mem_we       = 1'b0;
    clr          = 1'b0;
    if (accept) begin
      case (op)
        OP_RX: begin
          if (!rx_err) begin
            if (overflow || crlf) begin
              push         = 1'b1;
              np_nxt       = asm_row;
              count_nxt    = '0;
              fz_valid_nxt = 1'b0;
              last_cr_nxt  = 1'b0;
            end else begin
              mem_we      = 1'b1;
              count_nxt   = count_r + 1'b1;
              last_cr_nxt = (in_rx_byte == CH_CR);
              if (!fz_valid_r && (in_rx_byte == 8'h00)) begin
                fz_nxt       = count_r;
                fz_valid_nxt = 1'b1;
              end
            end
          end
        end
        OP_CLEAR: begin
          clr = slot_ok;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      np_r        <= '0;
      fz_r        <= '0;
      fz_valid_r  <= 1'b0;
      last_cr_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ROWS; i++) begin
        len_r[i] <= '0;
      end
    end else begin
      count_r     <= count_nxt;
      np_r        <= np_nxt;
      fz_r        <= fz_nxt;
      fz_valid_r  <= fz_valid_nxt;
      last_cr_r   <= last_cr_nxt;
      out_valid_r <= accept;
      if (push) begin
        len_r[asm_row] <= push_len;
      end else if (clr) begin
        len_r[ent] <= '0;
      end
    end
  end

  // line memory: one write port for assembly, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{asm_row, count_r}] <= in_rx_byte;
    end
    if (accept) begin
      rd_data_r <= mem[{ent, rd_col}];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_pushed_r <= push;
      pushed_len_r  <= push ? 6'(push_len) : 6'd0;
      rd_hit_r      <= (op == OP_READ) && slot_ok && rd_hit;
      slot_len_r    <= ((op == OP_READ) && slot_ok) ? 6'(slot_len) : 6'd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_line_pushed   = line_pushed_r;
  assign out_pushed_length = pushed_len_r;
  assign out_read_byte     = rd_hit_r ? rd_data_r : 8'h00;
  assign out_slot_length   = slot_len_r;

  `UCLQ_ASSERT_NXT(a_result_follows, clk, rst_n, start && !busy, out_valid, "missing result")
  `UCLQ_ASSERT_IMP(a_push_empties, clk, rst_n, out_valid && out_line_pushed, count_r == '0, "assembly not emptied after push")
  `UCLQ_ASSERT_IMP(a_zero_in_line, clk, rst_n, fz_valid_r, fz_r < count_r, "zero mark beyond assembly count")
  `UCLQ_ASSERT_IMP(a_cr_needs_data, clk, rst_n, last_cr_r, count_r != '0, "CR flag on empty assembly")
  `UCLQ_ASSERT_IMP(a_ptr_range, clk, rst_n, out_valid, {1'b0, np_r} < (ROW_W + 1)'(ROWS), "newest pointer out of range")

endmodule

`default_nettype wire
